// ===== hdl/iiwv_pkg.sv =====
// ---------------------------------------------------------------------------
// iiwv_pkg
// Shared types and constants of the integral image window variance unit.
// ---------------------------------------------------------------------------
package iiwv_pkg;

    // largest image, all field and table widths below are sized for it
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    // field widths
    localparam int PIX_W    = 8;
    localparam int POS_W    = 9;
    localparam int SIZE_W   = 10;
    localparam int DIM_W    = 10;
    localparam int SUM_W    = 26;
    localparam int SQ_W     = 35;
    localparam int SQ_OUT_W = 34;
    localparam int MEAN_W   = 24;
    localparam int VAR_W    = 30;
    localparam int STAT_W   = 2;
    localparam int RS_W     = 17;
    localparam int RSQ_W    = 25;

    // arithmetic widths of the statistics path
    localparam int AREA_W   = 20;
    localparam int DEN_W    = 40;
    localparam int NUM_W    = 54;
    localparam int QUO_W    = 30;
    localparam int DVD_W    = DEN_W + QUO_W;
    localparam int SQH_W    = 17;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_WIN   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_READY = 2'd2;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // window corners read from the tables
    localparam logic [1:0] CRN_BR = 2'd0;
    localparam logic [1:0] CRN_BL = 2'd1;
    localparam logic [1:0] CRN_TR = 2'd2;
    localparam logic [1:0] CRN_TL = 2'd3;

    typedef struct packed {
        logic              operation;
        logic [PIX_W-1:0]  pixel_value;
        logic [POS_W-1:0]  win_x;
        logic [POS_W-1:0]  win_y;
        logic [SIZE_W-1:0] win_w;
        logic [SIZE_W-1:0] win_h;
    } t_in;

    typedef struct packed {
        logic [SUM_W-1:0]    window_sum;
        logic [SQ_OUT_W-1:0] window_sq_sum;
        logic [MEAN_W-1:0]   mean_q16;
        logic [VAR_W-1:0]    variance_q16;
        logic [STAT_W-1:0]   status;
    } t_out;

    typedef struct packed {
        logic       ld_issue;
        logic       ld_write;
        logic       q_capture;
        logic       q_check;
        logic       rd_en;
        logic [1:0] rd_corner;
        logic       mul1;
        logic       mul2;
        logic       num;
        logic       div_start;
        logic       div_sel;
        logic       cap_var;
        logic       cap_mean;
    } t_cmd;

    typedef struct packed {
        logic q_bad;
        logic div_done;
    } t_stat;

endpackage

// ===== hdl/iiwv_div.sv =====
// ---------------------------------------------------------------------------
// iiwv_div
// Restoring divider, one quotient bit per cycle, fixed quotient width.
// ---------------------------------------------------------------------------
module iiwv_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [iiwv_pkg::DVD_W-1:0]    i_dividend,
    input  logic [iiwv_pkg::DEN_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [iiwv_pkg::QUO_W-1:0]    o_quot
);

    localparam int CNT_W = $clog2(iiwv_pkg::QUO_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [iiwv_pkg::DEN_W-1:0]  r_rem;
    logic [iiwv_pkg::QUO_W-1:0]  r_q;
    logic [iiwv_pkg::DEN_W:0]    trial;
    logic                        qbit;
    logic [iiwv_pkg::DEN_W-1:0]  n_rem;

    // trial subtraction
    always_comb begin
        trial = {r_rem, r_q[iiwv_pkg::QUO_W-1]};
        qbit  = (trial >= {1'b0, i_divisor});
        n_rem = qbit ? iiwv_pkg::DEN_W'(trial - {1'b0, i_divisor})
                     : trial[iiwv_pkg::DEN_W-1:0];
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(iiwv_pkg::QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[iiwv_pkg::DVD_W-1 -: iiwv_pkg::DEN_W];
            r_q   <= i_dividend[iiwv_pkg::QUO_W-1:0];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[iiwv_pkg::QUO_W-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== hdl/iiwv_dp.sv =====
// ---------------------------------------------------------------------------
// iiwv_dp
// Datapath: summed-area tables, load position, corner accumulation,
// multipliers and the shared divider.
// ---------------------------------------------------------------------------
module iiwv_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  iiwv_pkg::t_in                i_in,
    input  logic [iiwv_pkg::DIM_W-1:0]   i_wd,
    input  logic [iiwv_pkg::DIM_W-1:0]   i_ht,
    input  logic                         i_restart,
    input  iiwv_pkg::t_cmd               i_cmd,
    output iiwv_pkg::t_stat              o_stat,
    output iiwv_pkg::t_out               o_out
);

    localparam int CW    = $clog2(iiwv_pkg::MAX_WIDTH);
    localparam int RW    = $clog2(iiwv_pkg::MAX_HEIGHT);
    localparam int DEPTH = iiwv_pkg::MAX_WIDTH * iiwv_pkg::MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PL_W  = iiwv_pkg::AREA_W + iiwv_pkg::SQH_W;
    localparam int SS_W  = 2 * iiwv_pkg::SUM_W;

    function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] row,
                                              input logic [CW-1:0] col);
        return AW'(32'(row) * iiwv_pkg::MAX_WIDTH + 32'(col));
    endfunction

    // tables
    logic [iiwv_pkg::SUM_W-1:0] mem_sum [DEPTH];
    logic [iiwv_pkg::SQ_W-1:0]  mem_sq  [DEPTH];
    logic [iiwv_pkg::SUM_W-1:0] r_rd_sum;
    logic [iiwv_pkg::SQ_W-1:0]  r_rd_sq;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              crn_addr;

    // load state
    logic [CW-1:0]               r_col;
    logic [RW-1:0]               r_row;
    logic [iiwv_pkg::RS_W-1:0]   r_rs;
    logic [iiwv_pkg::RSQ_W-1:0]  r_rsq;
    logic                        r_fc;
    logic [AW-1:0]               r_waddr;
    logic [iiwv_pkg::RS_W-1:0]   r_wsum;
    logic [iiwv_pkg::RSQ_W-1:0]  r_wsq;
    logic                        r_up_ok;

    logic                        ld_restart;
    logic [CW-1:0]               col_e;
    logic [RW-1:0]               row_e;
    logic [iiwv_pkg::RS_W-1:0]   n_wsum;
    logic [iiwv_pkg::RSQ_W-1:0]  n_wsq;
    logic                        col_last;
    logic                        row_last;
    logic [iiwv_pkg::SUM_W-1:0]  n_tsum;
    logic [iiwv_pkg::SQ_W-1:0]   n_tsq;

    // query state
    logic [iiwv_pkg::POS_W-1:0]   r_x;
    logic [iiwv_pkg::POS_W-1:0]   r_y;
    logic [iiwv_pkg::SIZE_W-1:0]  r_w;
    logic [iiwv_pkg::SIZE_W-1:0]  r_h;
    logic [iiwv_pkg::STAT_W-1:0]  r_status;
    logic [iiwv_pkg::STAT_W-1:0]  n_status;
    logic [iiwv_pkg::AREA_W-1:0]  r_area;
    logic [iiwv_pkg::SUM_W-1:0]   r_s;
    logic [iiwv_pkg::SQ_W-1:0]    r_sq;
    logic                         r_acc_en;
    logic [1:0]                   r_acc_k;
    logic                         crn_incl;
    logic [10:0]                  x_end;
    logic [10:0]                  y_end;
    logic [RW-1:0]                row_hi;
    logic [RW-1:0]                row_lo;
    logic [CW-1:0]                col_hi;
    logic [CW-1:0]                col_lo;

    // statistics
    logic [SS_W-1:0]              mul_ss;
    logic [PL_W-1:0]              mul_lo;
    logic [PL_W-1:0]              mul_hi;
    logic [iiwv_pkg::DEN_W-1:0]   mul_den;
    logic [SS_W-1:0]              r_ss;
    logic [PL_W-1:0]              r_plo;
    logic [PL_W-1:0]              r_phi;
    logic [iiwv_pkg::DEN_W-1:0]   r_den;
    logic [iiwv_pkg::NUM_W-1:0]   r_num;
    logic [iiwv_pkg::MEAN_W-1:0]  r_mean;
    logic [iiwv_pkg::VAR_W-1:0]   r_var;
    logic [iiwv_pkg::DVD_W-1:0]   div_dividend;
    logic [iiwv_pkg::DEN_W-1:0]   div_divisor;
    logic                         div_done;
    logic [iiwv_pkg::QUO_W-1:0]   div_quot;
    logic                         res_ok;

    // load position, a finished or stale frame restarts at the origin
    always_comb begin
        ld_restart = r_fc || (32'(r_col) >= 32'(i_wd)) || (32'(r_row) >= 32'(i_ht));
        col_e      = ld_restart ? '0 : r_col;
        row_e      = ld_restart ? '0 : r_row;
        n_wsum     = (ld_restart ? '0 : r_rs) + iiwv_pkg::RS_W'(i_in.pixel_value);
        n_wsq      = (ld_restart ? '0 : r_rsq)
                   + iiwv_pkg::RSQ_W'({8'b0, i_in.pixel_value} * {8'b0, i_in.pixel_value});
        col_last   = (32'(col_e) + 1) >= 32'(i_wd);
        row_last   = (32'(row_e) + 1) >= 32'(i_ht);
        n_tsum     = (r_up_ok ? r_rd_sum : '0) + iiwv_pkg::SUM_W'(r_wsum);
        n_tsq      = (r_up_ok ? r_rd_sq : '0) + iiwv_pkg::SQ_W'(r_wsq);
    end

    // load position and row running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
            r_rs  <= '0;
            r_rsq <= '0;
            r_fc  <= 1'b0;
        end else if (i_cmd.ld_issue) begin
            r_fc <= col_last && row_last;
            if (col_last) begin
                r_col <= '0;
                r_rs  <= '0;
                r_rsq <= '0;
                r_row <= row_last ? '0 : RW'(row_e + 1'b1);
            end else begin
                r_col <= CW'(col_e + 1'b1);
                r_row <= row_e;
                r_rs  <= n_wsum;
                r_rsq <= n_wsq;
            end
        end
    end

    // table write data of the pending load
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_issue) begin
            r_waddr <= addr_of(row_e, col_e);
            r_wsum  <= n_wsum;
            r_wsq   <= n_wsq;
            r_up_ok <= (row_e != '0);
        end
    end

    // window geometry and corner addresses
    always_comb begin
        x_end  = 11'(r_x) + 11'(r_w);
        y_end  = 11'(r_y) + 11'(r_h);
        row_hi = RW'(y_end - 11'd1);
        col_hi = CW'(x_end - 11'd1);
        row_lo = RW'(11'(r_y) - 11'd1);
        col_lo = CW'(11'(r_x) - 11'd1);
        if (!r_fc) begin
            n_status = iiwv_pkg::ST_NOT_READY;
        end else if (r_w == '0 || r_h == '0 || x_end > {1'b0, i_wd}
                     || y_end > {1'b0, i_ht}) begin
            n_status = iiwv_pkg::ST_BAD_WIN;
        end else begin
            n_status = iiwv_pkg::ST_OK;
        end
        unique case (i_cmd.rd_corner)
            iiwv_pkg::CRN_BR: begin
                crn_addr = addr_of(row_hi, col_hi);
                crn_incl = 1'b1;
            end
            iiwv_pkg::CRN_BL: begin
                crn_addr = addr_of(row_hi, col_lo);
                crn_incl = (r_x != '0);
            end
            iiwv_pkg::CRN_TR: begin
                crn_addr = addr_of(row_lo, col_hi);
                crn_incl = (r_y != '0);
            end
            default: begin
                crn_addr = addr_of(row_lo, col_lo);
                crn_incl = (r_x != '0) && (r_y != '0);
            end
        endcase
        rd_addr = i_cmd.ld_issue ? addr_of(RW'(row_e - 1'b1), col_e) : crn_addr;
    end

    // table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_write) begin
            mem_sum[r_waddr] <= n_tsum;
            mem_sq[r_waddr]  <= n_tsq;
        end
        r_rd_sum <= mem_sum[rd_addr];
        r_rd_sq  <= mem_sq[rd_addr];
    end

    // corner accumulate tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
            r_acc_k  <= iiwv_pkg::CRN_BR;
        end else begin
            r_acc_en <= i_cmd.rd_en && crn_incl;
            r_acc_k  <= i_cmd.rd_corner;
        end
    end

    // multipliers
    always_comb begin
        mul_ss  = r_s * r_s;
        mul_lo  = r_area * r_sq[iiwv_pkg::SQH_W-1:0];
        mul_hi  = r_area * r_sq[iiwv_pkg::SQ_OUT_W-1:iiwv_pkg::SQH_W];
        mul_den = r_area * r_area;
    end

    // query capture, box sums and statistic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_capture) begin
            r_x <= i_in.win_x;
            r_y <= i_in.win_y;
            r_w <= i_in.win_w;
            r_h <= i_in.win_h;
        end
        if (i_cmd.q_check) begin
            r_status <= n_status;
            r_area   <= iiwv_pkg::AREA_W'(r_w) * iiwv_pkg::AREA_W'(r_h);
            r_s      <= '0;
            r_sq     <= '0;
        end else if (r_acc_en) begin
            if (r_acc_k == iiwv_pkg::CRN_BR || r_acc_k == iiwv_pkg::CRN_TL) begin
                r_s  <= r_s + r_rd_sum;
                r_sq <= r_sq + r_rd_sq;
            end else begin
                r_s  <= r_s - r_rd_sum;
                r_sq <= r_sq - r_rd_sq;
            end
        end
        if (i_cmd.mul1) begin
            r_ss  <= mul_ss;
            r_plo <= mul_lo;
        end
        if (i_cmd.mul2) begin
            r_phi <= mul_hi;
            r_den <= mul_den;
        end
        if (i_cmd.num) begin
            r_num <= iiwv_pkg::NUM_W'({r_phi, {iiwv_pkg::SQH_W{1'b0}}})
                   + iiwv_pkg::NUM_W'(r_plo) - iiwv_pkg::NUM_W'(r_ss);
        end
        if (i_cmd.cap_var) begin
            r_var <= iiwv_pkg::VAR_W'(div_quot);
        end
        if (i_cmd.cap_mean) begin
            r_mean <= iiwv_pkg::MEAN_W'(div_quot);
        end
    end

    // divider operands
    always_comb begin
        if (i_cmd.div_sel) begin
            div_dividend = iiwv_pkg::DVD_W'({r_s, 16'b0});
            div_divisor  = iiwv_pkg::DEN_W'(r_area);
        end else begin
            div_dividend = {r_num, 16'b0};
            div_divisor  = r_den;
        end
    end

    iiwv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // result, fields are zero unless the window was answered
    always_comb begin
        res_ok                = (r_status == iiwv_pkg::ST_OK);
        o_out.window_sum      = res_ok ? r_s : '0;
        o_out.window_sq_sum   = res_ok ? r_sq[iiwv_pkg::SQ_OUT_W-1:0] : '0;
        o_out.mean_q16        = res_ok ? r_mean : '0;
        o_out.variance_q16    = res_ok ? r_var : '0;
        o_out.status          = r_status;
        o_stat.q_bad          = !res_ok;
        o_stat.div_done       = div_done;
    end

endmodule

// ===== hdl/iiwv_ctrl.sv =====
// ---------------------------------------------------------------------------
// iiwv_ctrl
// Controller: sequences pixel loads and window queries over the datapath.
// ---------------------------------------------------------------------------
module iiwv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_op,
    input  iiwv_pkg::t_stat  i_stat,
    output iiwv_pkg::t_cmd   o_cmd,
    output logic             o_busy,
    output logic             o_valid
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LD_WR = 5'd1;
    localparam logic [4:0] S_Q_CHK = 5'd2;
    localparam logic [4:0] S_Q_DEC = 5'd3;
    localparam logic [4:0] S_RD0   = 5'd4;
    localparam logic [4:0] S_RD1   = 5'd5;
    localparam logic [4:0] S_RD2   = 5'd6;
    localparam logic [4:0] S_RD3   = 5'd7;
    localparam logic [4:0] S_ACC   = 5'd8;
    localparam logic [4:0] S_MUL1  = 5'd9;
    localparam logic [4:0] S_MUL2  = 5'd10;
    localparam logic [4:0] S_NUM   = 5'd11;
    localparam logic [4:0] S_VST   = 5'd12;
    localparam logic [4:0] S_VWT   = 5'd13;
    localparam logic [4:0] S_MST   = 5'd14;
    localparam logic [4:0] S_MWT   = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       accept;

    assign accept = i_start && (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = (i_op == iiwv_pkg::OP_LOAD) ? S_LD_WR : S_Q_CHK;
            S_LD_WR: n_state = S_IDLE;
            S_Q_CHK: n_state = S_Q_DEC;
            S_Q_DEC: n_state = i_stat.q_bad ? S_OUT : S_RD0;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_RD3;
            S_RD3:   n_state = S_ACC;
            S_ACC:   n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_NUM;
            S_NUM:   n_state = S_VST;
            S_VST:   n_state = S_VWT;
            S_VWT:   if (i_stat.div_done) n_state = S_MST;
            S_MST:   n_state = S_MWT;
            S_MWT:   if (i_stat.div_done) n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands to the datapath
    always_comb begin
        o_cmd.ld_issue  = accept && (i_op == iiwv_pkg::OP_LOAD);
        o_cmd.q_capture = accept && (i_op == iiwv_pkg::OP_QUERY);
        o_cmd.ld_write  = (r_state == S_LD_WR);
        o_cmd.q_check   = (r_state == S_Q_CHK);
        o_cmd.rd_en     = (r_state == S_RD0) || (r_state == S_RD1)
                       || (r_state == S_RD2) || (r_state == S_RD3);
        unique case (r_state)
            S_RD1:   o_cmd.rd_corner = iiwv_pkg::CRN_BL;
            S_RD2:   o_cmd.rd_corner = iiwv_pkg::CRN_TR;
            S_RD3:   o_cmd.rd_corner = iiwv_pkg::CRN_TL;
            default: o_cmd.rd_corner = iiwv_pkg::CRN_BR;
        endcase
        o_cmd.mul1      = (r_state == S_MUL1);
        o_cmd.mul2      = (r_state == S_MUL2);
        o_cmd.num       = (r_state == S_NUM);
        o_cmd.div_start = (r_state == S_VST) || (r_state == S_MST);
        o_cmd.div_sel   = (r_state == S_MST) || (r_state == S_MWT);
        o_cmd.cap_var   = (r_state == S_VWT) && i_stat.div_done;
        o_cmd.cap_mean  = (r_state == S_MWT) && i_stat.div_done;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    // a result is shown for one cycle only
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> (r_state == S_IDLE))
        else $error("result state not left after one cycle");

    // an accepted load writes its table entry in the following cycle
    a_load_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_issue |=> o_cmd.ld_write)
        else $error("load not followed by table write");

    // a divider start is never followed directly by another start
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !$past(o_cmd.div_start))
        else $error("divider started on consecutive cycles");

endmodule

// ===== hdl/integral_image_window_variance_unit.sv =====
// A pixel load reads the table entry of the row above, then writes its own entry.
// A window query reads the window corners, forms the products and runs the divider
// twice, for the variance and then the mean; it goes straight to the result when
// the frame is incomplete or the window is invalid. One item is handled at a time.
// Reset (synchronous, active low) clears the load position, running sums, frame
// flag and controller; table contents stay undefined until loaded.
// ---------------------------------------------------------------------------
// integral_image_window_variance_unit
// Summed-area tables of pixels and squared pixels with window sum, mean and
// variance queries, configured over an APB-style register port.
// ---------------------------------------------------------------------------
module integral_image_window_variance_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  iiwv_pkg::t_in    i_in,
    output logic             o_valid,
    output iiwv_pkg::t_out   o_out,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [iiwv_pkg::DIM_W-1:0] r_width;
    logic [iiwv_pkg::DIM_W-1:0] r_height;
    logic [iiwv_pkg::DIM_W-1:0] eff_wd;
    logic [iiwv_pkg::DIM_W-1:0] eff_ht;
    logic                       cfg_wr;
    iiwv_pkg::t_cmd             cmd;
    iiwv_pkg::t_stat            stat;

    // register transfer
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 10'd512;
            r_height <= 10'd512;
        end else if (cfg_wr) begin
            if (paddr[2] == iiwv_pkg::REG_WIDTH) begin
                r_width <= pwdata[iiwv_pkg::DIM_W-1:0];
            end else begin
                r_height <= pwdata[iiwv_pkg::DIM_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == iiwv_pkg::REG_HEIGHT) ? 32'(r_height) : 32'(r_width);

    // effective image size
    always_comb begin
        if (r_width == '0) begin
            eff_wd = iiwv_pkg::DIM_W'(1);
        end else if (32'(r_width) > iiwv_pkg::MAX_WIDTH) begin
            eff_wd = iiwv_pkg::DIM_W'(iiwv_pkg::MAX_WIDTH);
        end else begin
            eff_wd = r_width;
        end
        if (r_height == '0) begin
            eff_ht = iiwv_pkg::DIM_W'(1);
        end else if (32'(r_height) > iiwv_pkg::MAX_HEIGHT) begin
            eff_ht = iiwv_pkg::DIM_W'(iiwv_pkg::MAX_HEIGHT);
        end else begin
            eff_ht = r_height;
        end
    end

    iiwv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_in.operation),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    iiwv_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_wd      (eff_wd),
        .i_ht      (eff_ht),
        .i_restart (cfg_wr),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_out     (o_out)
    );

endmodule
